// ===== rtl/vertex_normal_accumulator_core_macros.svh =====
// Assertion macros shared by the vertex normal accumulator RTL.
`ifndef VERTEX_NORMAL_ACCUMULATOR_CORE_MACROS_SVH
`define VERTEX_NORMAL_ACCUMULATOR_CORE_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define VNA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define VNA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/vna_pkg.sv =====
// Shared constants and types of the vertex normal accumulator.
package vna_pkg;
    localparam int VERTEX_DEPTH = 1024;
    localparam int IDX_W = $clog2(VERTEX_DEPTH);
    localparam int CNT_W = $clog2(VERTEX_DEPTH + 1);
    localparam int IN_IDX_W = 16;
    localparam int COORD_W = 24;
    localparam int ACC_W = 64;
    localparam int UNIT_W = 16;
    localparam int CORNERS = 3;
    localparam int POS_W = 3 * COORD_W;
    localparam int ACCV_W = 3 * ACC_W;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_LOAD = 2'd0;
    localparam t_kind KIND_TRI = 2'd1;
    localparam t_kind KIND_READ = 2'd2;
endpackage

// ===== rtl/vna_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
module vna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/vna_norm.sv =====
// Iterative normalizer: scaling, sum of squares, bit-serial root and division.
module vna_norm (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic [vna_pkg::ACC_W-1:0] i_acc_x,
    input  logic [vna_pkg::ACC_W-1:0] i_acc_y,
    input  logic [vna_pkg::ACC_W-1:0] i_acc_z,
    output logic o_done,
    output logic o_valid,
    output logic signed [vna_pkg::UNIT_W-1:0] o_unit_x,
    output logic signed [vna_pkg::UNIT_W-1:0] o_unit_y,
    output logic signed [vna_pkg::UNIT_W-1:0] o_unit_z
);
    import vna_pkg::*;

    localparam logic [2:0] N_IDLE = 3'd0;
    localparam logic [2:0] N_SHIFT = 3'd1;
    localparam logic [2:0] N_SQ = 3'd2;
    localparam logic [2:0] N_SQRT = 3'd3;
    localparam logic [2:0] N_DSET = 3'd4;
    localparam logic [2:0] N_DIV = 3'd5;

    logic [2:0] r_state;
    logic [ACC_W-1:0] r_m [3];
    logic [ACC_W-1:0] r_mx;
    logic [2:0] r_neg;
    logic [1:0] r_k;
    logic [63:0] r_s;
    logic [63:0] r_rem;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [31:0] r_drem;
    logic [16:0] r_dnum;
    logic [16:0] r_q;
    logic [4:0] r_cnt;
    logic r_done;
    logic r_valid;
    logic signed [UNIT_W-1:0] r_u [3];

    logic [ACC_W-1:0] w_mag [3];
    logic [ACC_W-1:0] w_max;
    logic [30:0] w_mk;
    logic [61:0] w_sq;
    logic [63:0] w_rb;
    logic [46:0] w_num;
    logic [32:0] w_t;
    logic w_ge;
    logic [16:0] w_qn;
    logic [14:0] w_sat;
    logic signed [UNIT_W-1:0] w_signed;

    always_comb begin
        w_mag[0] = i_acc_x[ACC_W-1] ? (~i_acc_x + 64'd1) : i_acc_x;
        w_mag[1] = i_acc_y[ACC_W-1] ? (~i_acc_y + 64'd1) : i_acc_y;
        w_mag[2] = i_acc_z[ACC_W-1] ? (~i_acc_z + 64'd1) : i_acc_z;
        w_max = w_mag[0];
        if (w_mag[1] > w_max) begin
            w_max = w_mag[1];
        end
        if (w_mag[2] > w_max) begin
            w_max = w_mag[2];
        end
    end

    always_comb begin
        unique case (r_k)
            2'd0: w_mk = r_m[0][30:0];
            2'd1: w_mk = r_m[1][30:0];
            2'd2: w_mk = r_m[2][30:0];
            default: w_mk = '0;
        endcase
    end

    assign w_sq = w_mk * w_mk;
    assign w_rb = r_res + r_bit;
    assign w_num = {w_mk, 16'd0} - {w_mk, 15'd0} + {16'd0, r_res[31:1]};
    assign w_t = {r_drem, r_dnum[16]};
    assign w_ge = w_t >= {1'b0, r_res[31:0]};
    assign w_qn = {r_q[15:0], w_ge};
    assign w_sat = (w_qn > 17'd32767) ? 15'h7fff : w_qn[14:0];
    assign w_signed = r_neg[r_k] ? -$signed({1'b0, w_sat}) : $signed({1'b0, w_sat});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
            r_done <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                N_IDLE: begin
                    if (i_start) begin
                        r_m[0] <= w_mag[0];
                        r_m[1] <= w_mag[1];
                        r_m[2] <= w_mag[2];
                        r_mx <= w_max;
                        r_neg <= {i_acc_z[ACC_W-1], i_acc_y[ACC_W-1], i_acc_x[ACC_W-1]};
                        if (w_max == '0) begin
                            r_done <= 1'b1;
                            r_valid <= 1'b0;
                            r_u[0] <= '0;
                            r_u[1] <= '0;
                            r_u[2] <= '0;
                        end else begin
                            r_state <= N_SHIFT;
                        end
                    end
                end
                N_SHIFT: begin
                    if (r_mx[63:31] != '0) begin
                        r_mx <= r_mx >> 1;
                        r_m[0] <= r_m[0] >> 1;
                        r_m[1] <= r_m[1] >> 1;
                        r_m[2] <= r_m[2] >> 1;
                    end else if (!r_mx[30]) begin
                        r_mx <= r_mx << 1;
                        r_m[0] <= r_m[0] << 1;
                        r_m[1] <= r_m[1] << 1;
                        r_m[2] <= r_m[2] << 1;
                    end else begin
                        r_s <= '0;
                        r_k <= 2'd0;
                        r_state <= N_SQ;
                    end
                end
                N_SQ: begin
                    if (r_k == 2'd3) begin
                        r_rem <= r_s;
                        r_res <= '0;
                        r_bit <= 64'd1 << 62;
                        r_state <= N_SQRT;
                    end else begin
                        r_s <= r_s + {2'd0, w_sq};
                        r_k <= r_k + 2'd1;
                    end
                end
                N_SQRT: begin
                    if (r_rem >= w_rb) begin
                        r_rem <= r_rem - w_rb;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit == 64'd1) begin
                        r_k <= 2'd0;
                        r_state <= N_DSET;
                    end
                end
                N_DSET: begin
                    r_drem <= {2'd0, w_num[46:17]};
                    r_dnum <= w_num[16:0];
                    r_q <= '0;
                    r_cnt <= '0;
                    r_state <= N_DIV;
                end
                N_DIV: begin
                    r_dnum <= r_dnum << 1;
                    r_q <= w_qn;
                    r_drem <= w_ge ? 32'(w_t - {1'b0, r_res[31:0]}) : w_t[31:0];
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd16) begin
                        r_u[r_k] <= w_signed;
                        if (r_k == 2'd2) begin
                            r_done <= 1'b1;
                            r_valid <= 1'b1;
                            r_state <= N_IDLE;
                        end else begin
                            r_k <= r_k + 2'd1;
                            r_state <= N_DSET;
                        end
                    end
                end
                default: r_state <= N_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_valid = r_valid;
    assign o_unit_x = r_u[0];
    assign o_unit_y = r_u[1];
    assign o_unit_z = r_u[2];
endmodule

// ===== rtl/vertex_normal_accumulator_core.sv =====
// Top level of the vertex normal accumulator: control, cross product, memories.
// A transaction is taken when i_start is high and o_busy is low. A vertex load
// leaves o_busy low. A triangle makes three reads of the position memory, six
// products through one shared 25 by 25 multiplier, and a read and a write of
// the accumulator memory per corner. A triangle with a corner that is not
// loaded is dropped and leaves o_busy low. A read of a normal leaves o_busy low
// when the vertex is not loaded or no triangle has been seen. Otherwise it holds
// o_busy high through the normalizer, which skips its loops when the accumulator
// is zero and else runs the one-bit-a-cycle scaling loop, the 32-step square
// root and three 17-step divisions. Each result is shown for one cycle with
// o_strobe high, in the same cycle as o_busy falls when the read set it, and
// cannot be held off by the receiver. The memories need no clearing pass after
// reset.
`include "vertex_normal_accumulator_core_macros.svh"
module vertex_normal_accumulator_core (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_busy,
    input  logic [1:0] i_kind,
    input  logic signed [vna_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [vna_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [vna_pkg::COORD_W-1:0] i_coord_z,
    input  logic [vna_pkg::IN_IDX_W-1:0] i_first_index,
    input  logic [vna_pkg::IN_IDX_W-1:0] i_second_index,
    input  logic [vna_pkg::IN_IDX_W-1:0] i_third_index,
    output logic o_strobe,
    output logic signed [vna_pkg::UNIT_W-1:0] o_unit_x,
    output logic signed [vna_pkg::UNIT_W-1:0] o_unit_y,
    output logic signed [vna_pkg::UNIT_W-1:0] o_unit_z,
    output logic o_normal_valid
);
    import vna_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_TR0 = 4'd1;
    localparam logic [3:0] S_TR1 = 4'd2;
    localparam logic [3:0] S_TR2 = 4'd3;
    localparam logic [3:0] S_TR3 = 4'd4;
    localparam logic [3:0] S_EDGE = 4'd5;
    localparam logic [3:0] S_MUL = 4'd6;
    localparam logic [3:0] S_AR = 4'd7;
    localparam logic [3:0] S_AW = 4'd8;
    localparam logic [3:0] S_RD = 4'd9;
    localparam logic [3:0] S_RW = 4'd10;
    localparam logic [3:0] S_WAIT = 4'd11;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(VERTEX_DEPTH);

    logic [3:0] r_state;
    logic [CNT_W-1:0] r_count;
    logic r_seen;
    logic [IN_IDX_W-1:0] r_idx [CORNERS];
    logic [1:0] r_c;
    logic [2:0] r_k;
    logic signed [COORD_W-1:0] r_p [CORNERS][3];
    logic signed [COORD_W:0] r_a [3];
    logic signed [COORD_W:0] r_b [3];
    logic signed [2*COORD_W+1:0] r_prod;
    logic signed [2*COORD_W+1:0] r_pa;
    logic signed [2*COORD_W+2:0] r_n [3];
    logic r_strobe;
    logic r_valid;
    logic signed [UNIT_W-1:0] r_ux;
    logic signed [UNIT_W-1:0] r_uy;
    logic signed [UNIT_W-1:0] r_uz;

    logic w_take;
    logic w_in0;
    logic w_in1;
    logic w_in2;
    logic [IN_IDX_W-1:0] w_cidx;
    logic [IDX_W-1:0] w_pos_addr;
    logic [IDX_W-1:0] w_acc_addr;
    logic w_pos_we;
    logic w_acc_we;
    logic [POS_W-1:0] w_pos_rdata;
    logic [ACCV_W-1:0] w_acc_rdata;
    logic [ACCV_W-1:0] w_acc_wdata;
    logic signed [COORD_W:0] w_ma;
    logic signed [COORD_W:0] w_mb;
    logic signed [2*COORD_W+1:0] w_mul;
    logic w_norm_start;
    logic w_norm_done;
    logic w_norm_valid;
    logic signed [UNIT_W-1:0] w_nx;
    logic signed [UNIT_W-1:0] w_ny;
    logic signed [UNIT_W-1:0] w_nz;

    function automatic logic [ACC_W-1:0] sat_add(logic [ACC_W-1:0] a,
                                                 logic [2*COORD_W+2:0] b);
        logic [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {{(ACC_W-2*COORD_W-2){b[2*COORD_W+2]}}, b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return s[ACC_W-1:0];
    endfunction

    assign w_take = i_start && (r_state == S_IDLE);
    assign w_in0 = 32'(i_first_index) < 32'(r_count);
    assign w_in1 = 32'(i_second_index) < 32'(r_count);
    assign w_in2 = 32'(i_third_index) < 32'(r_count);
    assign w_cidx = r_idx[r_c];

    always_comb begin
        unique case (r_state)
            S_TR0: w_pos_addr = r_idx[0][IDX_W-1:0];
            S_TR1: w_pos_addr = r_idx[1][IDX_W-1:0];
            S_TR2: w_pos_addr = r_idx[2][IDX_W-1:0];
            default: w_pos_addr = r_count[IDX_W-1:0];
        endcase
        unique case (r_state)
            S_AR, S_AW: w_acc_addr = w_cidx[IDX_W-1:0];
            S_RD: w_acc_addr = r_idx[0][IDX_W-1:0];
            default: w_acc_addr = r_count[IDX_W-1:0];
        endcase
    end

    assign w_pos_we = w_take && (i_kind == KIND_LOAD) && (r_count < FULL_CNT);
    assign w_acc_we = w_pos_we || (r_state == S_AW);
    assign w_acc_wdata = (r_state == S_AW) ?
        {sat_add(w_acc_rdata[3*ACC_W-1:2*ACC_W], r_n[2]),
         sat_add(w_acc_rdata[2*ACC_W-1:ACC_W], r_n[1]),
         sat_add(w_acc_rdata[ACC_W-1:0], r_n[0])} : '0;

    vna_ram #(.WIDTH(POS_W), .DEPTH(VERTEX_DEPTH), .AW(IDX_W)) u_pos_ram (
        .i_clk(i_clk),
        .i_we(w_pos_we),
        .i_addr(w_pos_addr),
        .i_wdata({i_coord_z, i_coord_y, i_coord_x}),
        .o_rdata(w_pos_rdata)
    );

    vna_ram #(.WIDTH(ACCV_W), .DEPTH(VERTEX_DEPTH), .AW(IDX_W)) u_acc_ram (
        .i_clk(i_clk),
        .i_we(w_acc_we),
        .i_addr(w_acc_addr),
        .i_wdata(w_acc_wdata),
        .o_rdata(w_acc_rdata)
    );

    always_comb begin
        unique case (r_k)
            3'd0: begin w_ma = r_a[1]; w_mb = r_b[2]; end
            3'd1: begin w_ma = r_a[2]; w_mb = r_b[1]; end
            3'd2: begin w_ma = r_a[2]; w_mb = r_b[0]; end
            3'd3: begin w_ma = r_a[0]; w_mb = r_b[2]; end
            3'd4: begin w_ma = r_a[0]; w_mb = r_b[1]; end
            3'd5: begin w_ma = r_a[1]; w_mb = r_b[0]; end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    assign w_mul = w_ma * w_mb;
    assign w_norm_start = (r_state == S_RW);

    vna_norm u_norm (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_norm_start),
        .i_acc_x(w_acc_rdata[ACC_W-1:0]),
        .i_acc_y(w_acc_rdata[2*ACC_W-1:ACC_W]),
        .i_acc_z(w_acc_rdata[3*ACC_W-1:2*ACC_W]),
        .o_done(w_norm_done),
        .o_valid(w_norm_valid),
        .o_unit_x(w_nx),
        .o_unit_y(w_ny),
        .o_unit_z(w_nz)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_seen <= 1'b0;
            r_strobe <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_idx[0] <= i_first_index;
                        r_idx[1] <= i_second_index;
                        r_idx[2] <= i_third_index;
                        unique case (i_kind)
                            KIND_LOAD: begin
                                if (w_pos_we) begin
                                    r_count <= r_count + CNT_W'(1);
                                end
                            end
                            KIND_TRI: begin
                                if (w_in0 && w_in1 && w_in2) begin
                                    r_state <= S_TR0;
                                end
                            end
                            KIND_READ: begin
                                if (w_in0 && r_seen) begin
                                    r_state <= S_RD;
                                end else begin
                                    r_strobe <= 1'b1;
                                    r_ux <= '0;
                                    r_uy <= '0;
                                    r_uz <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_TR0: r_state <= S_TR1;
                S_TR1: begin
                    r_p[0][0] <= w_pos_rdata[COORD_W-1:0];
                    r_p[0][1] <= w_pos_rdata[2*COORD_W-1:COORD_W];
                    r_p[0][2] <= w_pos_rdata[3*COORD_W-1:2*COORD_W];
                    r_state <= S_TR2;
                end
                S_TR2: begin
                    r_p[1][0] <= w_pos_rdata[COORD_W-1:0];
                    r_p[1][1] <= w_pos_rdata[2*COORD_W-1:COORD_W];
                    r_p[1][2] <= w_pos_rdata[3*COORD_W-1:2*COORD_W];
                    r_state <= S_TR3;
                end
                S_TR3: begin
                    r_p[2][0] <= w_pos_rdata[COORD_W-1:0];
                    r_p[2][1] <= w_pos_rdata[2*COORD_W-1:COORD_W];
                    r_p[2][2] <= w_pos_rdata[3*COORD_W-1:2*COORD_W];
                    r_state <= S_EDGE;
                end
                S_EDGE: begin
                    for (int j = 0; j < 3; j++) begin
                        r_a[j] <= (COORD_W+1)'(r_p[1][j]) - (COORD_W+1)'(r_p[0][j]);
                        r_b[j] <= (COORD_W+1)'(r_p[2][j]) - (COORD_W+1)'(r_p[0][j]);
                    end
                    r_k <= 3'd0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod <= w_mul;
                    r_k <= r_k + 3'd1;
                    if (r_k != 3'd0) begin
                        if (r_k[0]) begin
                            r_pa <= r_prod;
                        end else begin
                            r_n[r_k[2:1] - 2'd1] <= (2*COORD_W+3)'(r_pa)
                                                  - (2*COORD_W+3)'(r_prod);
                        end
                    end
                    if (r_k == 3'd6) begin
                        r_c <= 2'd0;
                        r_state <= S_AR;
                    end
                end
                S_AR: r_state <= S_AW;
                S_AW: begin
                    if (r_c == 2'd2) begin
                        r_seen <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_c <= r_c + 2'd1;
                        r_state <= S_AR;
                    end
                end
                S_RD: r_state <= S_RW;
                S_RW: r_state <= S_WAIT;
                S_WAIT: begin
                    if (w_norm_done) begin
                        r_strobe <= 1'b1;
                        r_valid <= w_norm_valid;
                        r_ux <= w_nx;
                        r_uy <= w_ny;
                        r_uz <= w_nz;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_normal_valid = r_valid;
    assign o_unit_x = r_ux;
    assign o_unit_y = r_uy;
    assign o_unit_z = r_uz;

    `VNA_ASSERT_SAME(a_valid_strobe, i_clk, i_rst_n, o_normal_valid, o_strobe, "valid without strobe")
    `VNA_ASSERT_SAME(a_zero_invalid, i_clk, i_rst_n, o_strobe && !o_normal_valid, (o_unit_x == '0) && (o_unit_y == '0) && (o_unit_z == '0), "invalid result not zero")
    `VNA_ASSERT_SAME(a_unit_range, i_clk, i_rst_n, o_strobe, (o_unit_x != 16'sh8000) && (o_unit_y != 16'sh8000) && (o_unit_z != 16'sh8000), "unit component out of range")
    `VNA_ASSERT_SAME(a_rmw_order, i_clk, i_rst_n, r_state == S_AW, $past(r_state) == S_AR, "accumulator write without read")
endmodule

// ===== sim/vna_normal_checker.sv =====
// Checker that predicts vertex normal read results and compares them with the block.
`timescale 1ns / 1ps
module vna_normal_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_busy,
    input  logic [1:0] i_kind,
    input  logic signed [vna_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [vna_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [vna_pkg::COORD_W-1:0] i_coord_z,
    input  logic [vna_pkg::IN_IDX_W-1:0] i_first_index,
    input  logic [vna_pkg::IN_IDX_W-1:0] i_second_index,
    input  logic [vna_pkg::IN_IDX_W-1:0] i_third_index,
    input  logic i_strobe,
    input  logic signed [vna_pkg::UNIT_W-1:0] i_unit_x,
    input  logic signed [vna_pkg::UNIT_W-1:0] i_unit_y,
    input  logic signed [vna_pkg::UNIT_W-1:0] i_unit_z,
    input  logic i_normal_valid,
    output int o_errors,
    output int o_pending
);
    import vna_pkg::*;

    typedef struct packed {
        logic signed [UNIT_W-1:0] ux;
        logic signed [UNIT_W-1:0] uy;
        logic signed [UNIT_W-1:0] uz;
        logic nv;
    } t_unit_normal;

    longint pos_x [VERTEX_DEPTH];
    longint pos_y [VERTEX_DEPTH];
    longint pos_z [VERTEX_DEPTH];
    longint acc_x [VERTEX_DEPTH];
    longint acc_y [VERTEX_DEPTH];
    longint acc_z [VERTEX_DEPTH];
    int vertex_count;
    bit any_triangle;
    t_unit_normal expected_normals [$];

    function automatic longint add_clamped(input longint a, input longint b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
        return longint'(s[63:0]);
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] s);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= res + b) begin
                s = s - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic t_unit_normal unit_normal_of(input int i);
        t_unit_normal n;
        longint c [3];
        logic [63:0] m [3];
        logic [63:0] mx, s, r, q;
        logic signed [UNIT_W-1:0] v [3];
        n = '0;
        if (i >= vertex_count || !any_triangle) return n;
        c[0] = acc_x[i];
        c[1] = acc_y[i];
        c[2] = acc_z[i];
        mx = 0;
        for (int k = 0; k < 3; k++) begin
            m[k] = c[k] < 0 ? 64'(-c[k]) : 64'(c[k]);
            if (m[k] > mx) mx = m[k];
        end
        if (mx == 0) return n;
        while (mx >= 64'd1 << 31) begin
            mx = mx >> 1;
            for (int k = 0; k < 3; k++) m[k] = m[k] >> 1;
        end
        while (mx < 64'd1 << 30) begin
            mx = mx << 1;
            for (int k = 0; k < 3; k++) m[k] = m[k] << 1;
        end
        s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        r = root_floor(s);
        for (int k = 0; k < 3; k++) begin
            q = (m[k] * 64'd32768 + r / 2) / r;
            if (q > 64'd32767) q = 64'd32767;
            v[k] = c[k] < 0 ? -UNIT_W'(q) : UNIT_W'(q);
        end
        n.ux = v[0];
        n.uy = v[1];
        n.uz = v[2];
        n.nv = 1'b1;
        return n;
    endfunction

    task automatic accumulate_triangle(input int i0, input int i1, input int i2);
        longint ax, ay, az, bx, by, bz, nx, ny, nz;
        int corner [3];
        if (i0 >= vertex_count || i1 >= vertex_count || i2 >= vertex_count) return;
        ax = pos_x[i1] - pos_x[i0];
        ay = pos_y[i1] - pos_y[i0];
        az = pos_z[i1] - pos_z[i0];
        bx = pos_x[i2] - pos_x[i0];
        by = pos_y[i2] - pos_y[i0];
        bz = pos_z[i2] - pos_z[i0];
        nx = ay * bz - az * by;
        ny = az * bx - ax * bz;
        nz = ax * by - ay * bx;
        corner[0] = i0;
        corner[1] = i1;
        corner[2] = i2;
        foreach (corner[k]) begin
            acc_x[corner[k]] = add_clamped(acc_x[corner[k]], nx);
            acc_y[corner[k]] = add_clamped(acc_y[corner[k]], ny);
            acc_z[corner[k]] = add_clamped(acc_z[corner[k]], nz);
        end
        any_triangle = 1'b1;
    endtask

    assign o_pending = expected_normals.size();

    always @(posedge i_clk) begin
        t_unit_normal want, got;
        if (!i_rst_n) begin
            vertex_count = 0;
            any_triangle = 1'b0;
            expected_normals.delete();
            o_errors <= 0;
        end else begin
            if (i_strobe) begin
                got = '{i_unit_x, i_unit_y, i_unit_z, i_normal_valid};
                if (expected_normals.size() == 0) begin
                    if (o_errors < 10)
                        $display("%0t: unexpected result transaction %p", $realtime, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_normals.pop_front();
                    if (got !== want) begin
                        if (o_errors < 10)
                            $display("%0t: normal mismatch: expected %p, actual %p",
                                     $realtime, want, got);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_start && !i_busy) begin
                case (i_kind)
                    KIND_LOAD: begin
                        if (vertex_count < VERTEX_DEPTH) begin
                            pos_x[vertex_count] = longint'(i_coord_x);
                            pos_y[vertex_count] = longint'(i_coord_y);
                            pos_z[vertex_count] = longint'(i_coord_z);
                            acc_x[vertex_count] = 0;
                            acc_y[vertex_count] = 0;
                            acc_z[vertex_count] = 0;
                            vertex_count++;
                        end
                    end
                    KIND_TRI: accumulate_triangle(i_first_index, i_second_index,
                                                  i_third_index);
                    KIND_READ: expected_normals = {expected_normals,
                                                   unit_normal_of(i_first_index)};
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== sim/testbench.sv =====
// Top of the vertex normal accumulator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
    import vna_pkg::*;

    localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam t_kind KIND_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic [1:0] i_kind = KIND_LOAD;
    logic signed [COORD_W-1:0] i_coord_x = '0;
    logic signed [COORD_W-1:0] i_coord_y = '0;
    logic signed [COORD_W-1:0] i_coord_z = '0;
    logic [IN_IDX_W-1:0] i_first_index = '0;
    logic [IN_IDX_W-1:0] i_second_index = '0;
    logic [IN_IDX_W-1:0] i_third_index = '0;
    logic o_busy, o_strobe, o_normal_valid;
    logic signed [UNIT_W-1:0] o_unit_x, o_unit_y, o_unit_z;
    int mismatches, outstanding;
    int loads_sent = 0;
    bit idling = 1'b1;

    vertex_normal_accumulator_core dut (.*);

    vna_normal_checker checker_i (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_kind,
        .i_coord_x, .i_coord_y, .i_coord_z,
        .i_first_index, .i_second_index, .i_third_index,
        .i_strobe(o_strobe), .i_unit_x(o_unit_x), .i_unit_y(o_unit_y),
        .i_unit_z(o_unit_z), .i_normal_valid(o_normal_valid),
        .o_errors(mismatches), .o_pending(outstanding)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic issue(input t_kind k, input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                         input logic [COORD_W-1:0] z, input int a, input int b, input int c);
        if (idling && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_kind <= k;
        i_coord_x <= x;
        i_coord_y <= y;
        i_coord_z <= z;
        i_first_index <= IN_IDX_W'(a);
        i_second_index <= IN_IDX_W'(b);
        i_third_index <= IN_IDX_W'(c);
        i_start <= 1'b1;
        @(negedge i_clk);
        while (o_busy) @(negedge i_clk);
        @(posedge i_clk);
        if (k == KIND_LOAD) loads_sent++;
    endtask

    task automatic load_vertex(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                               input logic [COORD_W-1:0] z);
        issue(KIND_LOAD, x, y, z, $urandom, $urandom, $urandom);
    endtask

    task automatic triangle(input int a, input int b, input int c);
        issue(KIND_TRI, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom), a, b, c);
    endtask

    task automatic read_normal(input int a);
        issue(KIND_READ, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
              a, $urandom, $urandom);
    endtask

    task automatic drain_results();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    function automatic int vertex_index();
        int stored;
        stored = loads_sent < VERTEX_DEPTH ? loads_sent : VERTEX_DEPTH;
        if (stored > 0 && $urandom_range(0, 99) < 88) return $urandom_range(0, stored - 1);
        return $urandom_range(0, 65535);
    endfunction

    function automatic logic [COORD_W-1:0] coordinate();
        case ($urandom_range(0, 5))
            0: return C_MIN;
            1: return C_MAX;
            2: return COORD_W'($urandom_range(0, 8191) - 4096);
            default: return COORD_W'($urandom);
        endcase
    endfunction

    initial begin
        int pick;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        read_normal(0);
        load_vertex(C_MIN, C_MAX, C_MIN);
        load_vertex(C_MAX, C_MIN, C_MIN);
        load_vertex(C_MIN, C_MIN, C_MAX);
        read_normal(0);
        triangle(0, 1, 3);
        triangle(65535, 0, 1);
        triangle(0, 2, 65535);
        read_normal(1);
        triangle(0, 0, 1);
        read_normal(0);
        issue(KIND_UNUSED, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom), 0, 1, 2);
        triangle(0, 1, 2);
        read_normal(0);
        read_normal(1);
        read_normal(2);
        read_normal(3);
        read_normal(65535);
        load_vertex('0, '0, '0);
        load_vertex(24'h000001, 24'hFFFFFF, 24'h001000);
        load_vertex(24'h001000, 24'h000001, 24'hFFF000);
        triangle(3, 4, 5);
        triangle(5, 4, 3);
        read_normal(4);

        for (int n = 0; n < 800; n++) begin
            if (n % 300 == 250) idling = ~idling;
            pick = $urandom_range(0, 99);
            if (pick < 33 && loads_sent < 600)
                load_vertex(coordinate(), coordinate(), coordinate());
            else if (pick < 75)
                triangle(vertex_index(), vertex_index(), vertex_index());
            else if (pick < 96)
                read_normal(vertex_index());
            else
                issue(KIND_UNUSED, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                      $urandom, $urandom, $urandom);
            if (n == 700) drain_results();
        end

        idling = 1'b0;
        drain_results();
        for (int n = 0; n < 20; n++) triangle(0, 1, 2);
        read_normal(0);
        read_normal(1);
        read_normal(2);

        while (loads_sent < VERTEX_DEPTH + 3)
            load_vertex(coordinate(), coordinate(), coordinate());
        triangle(VERTEX_DEPTH - 3, VERTEX_DEPTH - 2, VERTEX_DEPTH - 1);
        triangle(VERTEX_DEPTH - 1, 0, VERTEX_DEPTH);
        read_normal(VERTEX_DEPTH - 1);
        read_normal(VERTEX_DEPTH);
        for (int n = 0; n < 40; n++) begin
            triangle(vertex_index(), vertex_index(), vertex_index());
            read_normal(vertex_index());
        end

        drain_results();
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
